[rtl/sprite_animation_timer_assert.svh]
// Assertion macros for the sprite animation timer.
`ifndef SPRITE_ANIMATION_TIMER_ASSERT_SVH
`define SPRITE_ANIMATION_TIMER_ASSERT_SVH
`ifndef SYNTH
// Clocked check, off while reset is high.
`define SAT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds through reset.
`define SAT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAT_ASSERT(label, clk, rst, prop, msg)
`define SAT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[rtl/sat_pkg.sv]
// Shared types and constants for the sprite animation timer.
package sat_pkg;

   localparam int MAX_FRAMES  = 256;
   localparam int FRAME_LIMIT = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
   localparam int TOTAL_W     = 9;

   localparam int DIV_DIVIDEND_W = 33;
   localparam int DIV_DIVISOR_W  = 16;
   localparam int DIV_STEP_W     = $clog2(DIV_DIVIDEND_W);

   localparam int REQ_W = 16;
   localparam int RSP_W = 80;
   localparam int CSR_W = 16;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_PERIOD = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MOVE_PERIOD  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_TOTAL  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOOP_ENABLE  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_X_DIRECTION  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_Y_DIRECTION  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_X_SPEED      = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_Y_SPEED      = 3'd7;

   localparam logic [15:0] FRAME_PERIOD_RESET = 16'd60;
   localparam logic [15:0] MOVE_PERIOD_RESET  = 16'd30;

   localparam logic [1:0] DIR_NONE   = 2'b00;
   localparam logic [1:0] DIR_POS    = 2'b01;
   localparam logic [1:0] DIR_NEG2   = 2'b10;
   localparam logic [1:0] DIR_NEG    = 2'b11;

   typedef struct packed {
      logic                      done;
      logic [DIV_DIVIDEND_W-1:0] quotient;
      logic [DIV_DIVISOR_W-1:0]  remainder;
   } div_result_type;

endpackage

[rtl/sprite_animation_timer.sv]
// Sprite animation timer: frame counter and position tracker driven by tick requests.
//
// A request on req_ carries the milliseconds elapsed since the previous tick. The
// block adds it to a frame and a move accumulator (both saturating), steps the frame
// index and the x/y position by the whole periods found, and returns one response
// on rsp_ with the frame index, both positions and the alive flag. The user writes
// configuration via csr_ (index, data, write enable) only while idle; not enforced.
//
// One request is worked at a time. Whole periods and the looping frame wrap come
// from a single shared restoring divider at one bit per cycle (up to three passes a
// tick); the 12x32 multiplies for the two axes run in separate states. A tick with
// no whole period passes S_FRAME, S_MOVE and S_OUT; a looping tick that also moves
// adds S_FDIV, S_FMOD, S_MDIV, S_MULX, S_MULY and S_ADDY. req_tready is high only
// while idle, so the next request is taken only after the response is loaded.
//
// Reset (synchronous, active high) loads the register defaults, clears the
// accumulators, frame and positions, and sets the alive flag. If the receiver
// stalls, the response holds in the output register and the next request is
// still taken; its own response waits until the held one is accepted.
module sprite_animation_timer import sat_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // elapsed_ms [15:0]
   input  logic [REQ_W-1:0]      req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // frame_index [7:0], x_pos [39:8], y_pos [71:40], alive [72], zero fill above
   output logic [RSP_W-1:0]      rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata
);

`include "sprite_animation_timer_assert.svh"

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FRAME = 4'd1;
   localparam logic [3:0] S_FDIV  = 4'd2;
   localparam logic [3:0] S_FMOD  = 4'd3;
   localparam logic [3:0] S_MOVE  = 4'd4;
   localparam logic [3:0] S_MDIV  = 4'd5;
   localparam logic [3:0] S_MULX  = 4'd6;
   localparam logic [3:0] S_MULY  = 4'd7;
   localparam logic [3:0] S_ADDY  = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   logic [15:0]        frame_period_ff, move_period_ff;
   logic [TOTAL_W-1:0] frame_total_ff;
   logic               loop_en_ff;
   logic [1:0]         x_dir_ff, y_dir_ff;
   logic [11:0]        x_speed_ff, y_speed_ff;

   logic [3:0]         state_ff, state_in;
   logic [31:0]        facc_ff, facc_in;
   logic [31:0]        macc_ff, macc_in;
   logic [7:0]         cur_frame_ff, cur_frame_in;
   logic [31:0]        x_pos_ff, x_pos_in;
   logic [31:0]        y_pos_ff, y_pos_in;
   logic               alive_ff, alive_in;
   logic [31:0]        cnt_ff, cnt_in;
   logic [31:0]        step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [TOTAL_W-1:0]        total_eff;
   logic [32:0]               facc_sum, macc_sum, next_frame;
   logic                      div_start;
   logic [DIV_DIVIDEND_W-1:0] div_dividend;
   logic [DIV_DIVISOR_W-1:0]  div_divisor;
   div_result_type            div_res;

   function automatic logic [31:0] move_axis(input logic [31:0] pos, input logic [1:0] dir,
                                             input logic [31:0] step);
      logic [31:0] res;
      unique case (dir)
         DIR_POS:  res = pos + step;
         DIR_NEG:  res = pos - step;
         DIR_NEG2: res = pos - {step[30:0], 1'b0};
         DIR_NONE: res = pos;
         default:  res = pos;
      endcase
      return res;
   endfunction

   sat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

   always_comb begin
      if (frame_total_ff == '0) begin
         total_eff = TOTAL_W'(1);
      end else if (frame_total_ff > TOTAL_W'(FRAME_LIMIT)) begin
         total_eff = TOTAL_W'(FRAME_LIMIT);
      end else begin
         total_eff = frame_total_ff;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      facc_in      = facc_ff;
      macc_in      = macc_ff;
      cur_frame_in = cur_frame_ff;
      x_pos_in     = x_pos_ff;
      y_pos_in     = y_pos_ff;
      alive_in     = alive_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      div_dividend = {1'b0, facc_ff};
      div_divisor  = frame_period_ff;

      facc_sum   = {1'b0, facc_ff} + 33'(req_tdata);
      macc_sum   = {1'b0, macc_ff} + 33'(req_tdata);
      next_frame = 33'(cur_frame_ff) + div_res.quotient;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               facc_in  = facc_sum[32] ? '1 : facc_sum[31:0];
               macc_in  = macc_sum[32] ? '1 : macc_sum[31:0];
               state_in = S_FRAME;
            end
         end
         S_FRAME: begin
            if (total_eff == TOTAL_W'(1) || frame_period_ff == '0 ||
                facc_ff < 32'(frame_period_ff)) begin
               state_in = S_MOVE;
            end else begin
               div_start = 1'b1;
               state_in  = S_FDIV;
            end
         end
         S_FDIV: begin
            if (div_res.done) begin
               facc_in = 32'(div_res.remainder);
               if (loop_en_ff) begin
                  // wrap the advanced index through a second pass
                  div_start    = 1'b1;
                  div_dividend = next_frame;
                  div_divisor  = 16'(total_eff);
                  state_in     = S_FMOD;
               end else begin
                  if (next_frame >= 33'(total_eff)) begin
                     cur_frame_in = 8'(total_eff - 1'b1);
                     alive_in     = 1'b0;
                  end else begin
                     cur_frame_in = next_frame[7:0];
                  end
                  state_in = S_MOVE;
               end
            end
         end
         S_FMOD: begin
            if (div_res.done) begin
               cur_frame_in = div_res.remainder[7:0];
               state_in     = S_MOVE;
            end
         end
         S_MOVE: begin
            if (move_period_ff == '0 || macc_ff < 32'(move_period_ff)) begin
               state_in = S_OUT;
            end else begin
               div_start    = 1'b1;
               div_dividend = {1'b0, macc_ff};
               div_divisor  = move_period_ff;
               state_in     = S_MDIV;
            end
         end
         S_MDIV: begin
            if (div_res.done) begin
               macc_in  = 32'(div_res.remainder);
               cnt_in   = div_res.quotient[31:0];
               state_in = S_MULX;
            end
         end
         S_MULX: begin
            step_in  = 32'(x_speed_ff) * cnt_ff;
            state_in = S_MULY;
         end
         S_MULY: begin
            x_pos_in = move_axis(x_pos_ff, x_dir_ff, step_ff);
            step_in  = 32'(y_speed_ff) * cnt_ff;
            state_in = S_ADDY;
         end
         S_ADDY: begin
            y_pos_in = move_axis(y_pos_ff, y_dir_ff, step_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, alive_ff, y_pos_ff, x_pos_ff, cur_frame_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_period_ff <= FRAME_PERIOD_RESET;
         move_period_ff  <= MOVE_PERIOD_RESET;
         frame_total_ff  <= TOTAL_W'(1);
         loop_en_ff      <= 1'b0;
         x_dir_ff        <= DIR_NONE;
         y_dir_ff        <= DIR_NONE;
         x_speed_ff      <= '0;
         y_speed_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_FRAME_PERIOD: frame_period_ff <= csr_wdata;
            CSR_MOVE_PERIOD:  move_period_ff  <= csr_wdata;
            CSR_FRAME_TOTAL:  frame_total_ff  <= csr_wdata[TOTAL_W-1:0];
            CSR_LOOP_ENABLE:  loop_en_ff      <= csr_wdata[0];
            CSR_X_DIRECTION:  x_dir_ff        <= csr_wdata[1:0];
            CSR_Y_DIRECTION:  y_dir_ff        <= csr_wdata[1:0];
            CSR_X_SPEED:      x_speed_ff      <= csr_wdata[11:0];
            CSR_Y_SPEED:      y_speed_ff      <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         facc_ff      <= '0;
         macc_ff      <= '0;
         cur_frame_ff <= '0;
         x_pos_ff     <= '0;
         y_pos_ff     <= '0;
         alive_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         facc_ff      <= facc_in;
         macc_ff      <= macc_in;
         cur_frame_ff <= cur_frame_in;
         x_pos_ff     <= x_pos_in;
         y_pos_ff     <= y_pos_in;
         alive_ff     <= alive_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   `SAT_ASSERT(a_alive_sticky, clock, reset, !alive_ff |=> !alive_ff, "alive flag set again without reset")
   `SAT_ASSERT_ALWAYS(a_div_start_state, clock, div_start |-> (state_ff == S_FRAME || state_ff == S_FDIV || state_ff == S_MOVE), "divider started outside a divide step")
   `SAT_ASSERT(a_out_load, clock, reset, (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) |=> (rsp_tvalid && state_ff == S_IDLE), "response not loaded when output register was free")
   `SAT_ASSERT(a_fmod_range, clock, reset, (state_ff == S_FMOD && div_res.done) |-> (div_res.remainder < 16'(total_eff)), "wrapped frame index out of range")

endmodule

[rtl/sat_div.sv]
// Restoring divider, one quotient bit per cycle.
module sat_div import sat_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DIV_DIVIDEND_W-1:0] dividend,
   input  logic [DIV_DIVISOR_W-1:0]  divisor,
   output div_result_type            result
);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [DIV_STEP_W-1:0]     step_ff, step_in;
   logic [DIV_DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIV_DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIV_DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIV_DIVISOR_W:0]    trial;
   logic [DIV_DIVISOR_W:0]    diff;
   logic                      fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIV_DIVIDEND_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = (trial >= {1'b0, divisor_ff});

      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;

      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIV_DIVISOR_W-1:0] : trial[DIV_DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIV_DIVIDEND_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_W'(DIV_DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule

[tb/sprite_animation_timer_test.sv]
// Self-checking testbench for the sprite animation timer: tick requests, register settings.
`timescale 1ns / 100ps

module sprite_animation_timer_test;
   import sat_pkg::*;

   localparam int          HALF_PERIOD  = 6;
   localparam int          LIMIT_CYCLES = 4_000_000;
   localparam int          LONG_HOLD    = 400;
   localparam int          DRAIN_CYCLES = 200;
   localparam logic [8:0]  FRAME_CAP    = 9'd256;

   // Field order from the lowest bit up: frame_index, x_pos, y_pos, alive.
   typedef struct packed {
      logic        alive;
      logic [31:0] y_pos;
      logic [31:0] x_pos;
      logic [7:0]  frame_index;
   } tick_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   // Register copies used for prediction.
   logic [15:0] cfg_frame_period = FRAME_PERIOD_RESET;
   logic [15:0] cfg_move_period  = MOVE_PERIOD_RESET;
   logic [8:0]  cfg_frame_total  = 9'd1;
   logic        cfg_loop         = 1'b0;
   logic [1:0]  cfg_x_dir        = DIR_NONE;
   logic [1:0]  cfg_y_dir        = DIR_NONE;
   logic [11:0] cfg_x_speed      = '0;
   logic [11:0] cfg_y_speed      = '0;

   // Predicted sprite state.
   logic [31:0] frame_acc = '0;
   logic [31:0] move_acc  = '0;
   logic [7:0]  cur_frame = '0;
   logic [31:0] x_now     = '0;
   logic [31:0] y_now     = '0;
   logic        alive_now = 1'b1;

   logic [15:0]     tick_queue[$];
   tick_result_type pending_results[$];

   int  send_idle_pct = 25;
   int  recv_idle_pct = 75;
   bit  sender_paused = 1'b0;
   bit  req_fired = 1'b0;
   int  holds_asked = 0;
   int  holds_granted = 0;
   int  hold_left = 0;
   int  ticks_issued = 0;
   int  ticks_accepted = 0;
   int  ticks_checked = 0;
   int  csr_writes = 0;
   int  failures = 0;

   sprite_animation_timer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #HALF_PERIOD clock = ~clock;
   end

   function automatic logic [31:0] add_clamped(logic [31:0] acc, logic [15:0] ms);
      logic [32:0] sum;
      sum = {1'b0, acc} + {17'd0, ms};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   function automatic logic [31:0] step_axis(logic [31:0] pos, logic [1:0] dir,
                                             logic [11:0] speed, logic [31:0] steps);
      logic [63:0] prod;
      logic [31:0] travel;
      prod = {52'd0, speed} * {32'd0, steps};
      travel = prod[31:0];
      case (dir)
         DIR_POS:  return pos + travel;
         DIR_NEG:  return pos - travel;
         DIR_NEG2: return pos - travel - travel;
         default:  return pos;
      endcase
   endfunction

   // Apply one tick to the predicted state and return the response it should produce.
   function automatic tick_result_type advance_tick(logic [15:0] ms);
      logic [8:0]      total;
      logic [31:0]     periods;
      logic [32:0]     next_frame;
      tick_result_type res;
      frame_acc = add_clamped(frame_acc, ms);
      move_acc  = add_clamped(move_acc, ms);
      if (cfg_frame_total == 9'd0)
         total = 9'd1;
      else if (cfg_frame_total > FRAME_CAP)
         total = FRAME_CAP;
      else
         total = cfg_frame_total;
      if (total != 9'd1 && cfg_frame_period != 16'd0 && frame_acc >= {16'd0, cfg_frame_period})
      begin
         periods    = frame_acc / {16'd0, cfg_frame_period};
         frame_acc  = frame_acc % {16'd0, cfg_frame_period};
         next_frame = {25'd0, cur_frame} + {1'b0, periods};
         // a non-looping run pins to the last frame and kills the sprite
         if (!cfg_loop && next_frame >= {24'd0, total}) begin
            next_frame = {24'd0, total} - 33'd1;
            alive_now  = 1'b0;
         end
         cur_frame = 8'(next_frame % {24'd0, total});
      end
      if (cfg_move_period != 16'd0 && move_acc >= {16'd0, cfg_move_period}) begin
         periods  = move_acc / {16'd0, cfg_move_period};
         move_acc = move_acc % {16'd0, cfg_move_period};
         x_now    = step_axis(x_now, cfg_x_dir, cfg_x_speed, periods);
         y_now    = step_axis(y_now, cfg_y_dir, cfg_y_speed, periods);
      end
      res.frame_index = cur_frame;
      res.x_pos       = x_now;
      res.y_pos       = y_now;
      res.alive       = alive_now;
      return res;
   endfunction

   // Request driver: hold a request until taken, then offer the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (tick_queue.size() != 0 && !sender_paused && $urandom_range(99) >= send_idle_pct)
         begin
            req_tdata  <= tick_queue.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response receiver: random stalls plus the occasional long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holds_granted != holds_asked) begin
         holds_granted = holds_asked;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: check responses against the oldest prediction, predict accepted requests.
   always @(posedge clock) begin
      tick_result_type want;
      tick_result_type got;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got = tick_result_type'(rsp_tdata[72:0]);
            if (pending_results.size() == 0) begin
               $display("%0t: response with no tick pending: %h", $time, rsp_tdata);
               failures++;
            end else begin
               want = pending_results.pop_front();
               ticks_checked++;
               if (got.frame_index !== want.frame_index) begin
                  $display("%0t: frame_index expected %0d actual %0d", $time,
                           want.frame_index, got.frame_index);
                  failures++;
               end
               if (got.x_pos !== want.x_pos) begin
                  $display("%0t: x_pos expected %h actual %h", $time, want.x_pos, got.x_pos);
                  failures++;
               end
               if (got.y_pos !== want.y_pos) begin
                  $display("%0t: y_pos expected %h actual %h", $time, want.y_pos, got.y_pos);
                  failures++;
               end
               if (got.alive !== want.alive) begin
                  $display("%0t: alive expected %b actual %b", $time, want.alive, got.alive);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_results.push_back(advance_tick(req_tdata));
            ticks_accepted++;
         end
      end
   end

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      case (addr)
         CSR_FRAME_PERIOD: cfg_frame_period = value;
         CSR_MOVE_PERIOD:  cfg_move_period  = value;
         CSR_FRAME_TOTAL:  cfg_frame_total  = value[8:0];
         CSR_LOOP_ENABLE:  cfg_loop         = value[0];
         CSR_X_DIRECTION:  cfg_x_dir        = value[1:0];
         CSR_Y_DIRECTION:  cfg_y_dir        = value[1:0];
         CSR_X_SPEED:      cfg_x_speed      = value[11:0];
         CSR_Y_SPEED:      cfg_y_speed      = value[11:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      csr_writes++;
   endtask

   task automatic add_tick(input logic [15:0] ms);
      tick_queue.push_back(ms);
      ticks_issued++;
   endtask

   // Wait out the queued ticks, optionally with a receiver hold-off or a sender pause.
   task automatic finish_batch(input bit with_hold, input bit with_pause);
      int base;
      int half;
      base = ticks_accepted;
      half = (ticks_issued - base) / 2;
      if (with_hold) begin
         @(posedge clock);
         holds_asked++;
      end
      if (with_pause) begin
         do @(negedge clock); while (ticks_accepted < base + half);
         @(posedge clock);
         sender_paused = 1'b1;
         do @(negedge clock); while (req_tvalid || pending_results.size() != 0);
         @(posedge clock);
         sender_paused = 1'b0;
      end
      do @(negedge clock);
      while (ticks_accepted != ticks_issued || pending_results.size() != 0);
   endtask

   function automatic logic [15:0] pick_elapsed();
      int span;
      span = ($urandom_range(1) ? int'(cfg_frame_period) : int'(cfg_move_period)) * 3;
      if (span == 0 || span > 65535)
         span = 65535;
      case ($urandom_range(9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2, 3, 4, 5: return 16'($urandom_range(span));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_period();
      case ($urandom_range(5))
         0:       return 16'd1;
         1:       return 16'hFFFF;
         2:       return 16'd0;
         3, 4:    return 16'($urandom_range(1, 200));
         default: return 16'($urandom_range(1, 65535));
      endcase
   endfunction

   function automatic logic [15:0] pick_total();
      logic [8:0] t;
      case ($urandom_range(7))
         0:       t = 9'd0;
         1:       t = 9'd1;
         2:       t = 9'd2;
         3:       t = FRAME_CAP;
         4:       t = 9'($urandom_range(257, 511));
         5, 6:    t = 9'($urandom_range(2, 12));
         default: t = 9'($urandom_range(1, 256));
      endcase
      return {7'($urandom), t};
   endfunction

   function automatic logic [15:0] pick_speed();
      logic [11:0] sp;
      case ($urandom_range(3))
         0:       sp = 12'd0;
         1:       sp = 12'hFFF;
         default: sp = 12'($urandom);
      endcase
      return {4'($urandom), sp};
   endfunction

   // Mode 1: low extremes, mode 2: high extremes, otherwise random.
   task automatic pick_settings(input int mode);
      if (mode == 1) begin
         write_csr(CSR_FRAME_PERIOD, 16'd1);
         write_csr(CSR_MOVE_PERIOD, 16'd1);
         write_csr(CSR_FRAME_TOTAL, 16'd1);
         write_csr(CSR_LOOP_ENABLE, 16'd0);
         write_csr(CSR_X_DIRECTION, {14'h3FFF, DIR_NEG});
         write_csr(CSR_Y_DIRECTION, {14'h3FFF, DIR_NEG});
         write_csr(CSR_X_SPEED, 16'd0);
         write_csr(CSR_Y_SPEED, 16'd0);
      end else if (mode == 2) begin
         write_csr(CSR_FRAME_PERIOD, 16'hFFFF);
         write_csr(CSR_MOVE_PERIOD, 16'hFFFF);
         write_csr(CSR_FRAME_TOTAL, {7'd0, FRAME_CAP});
         write_csr(CSR_LOOP_ENABLE, 16'd1);
         write_csr(CSR_X_DIRECTION, {14'd0, DIR_POS});
         write_csr(CSR_Y_DIRECTION, {14'd0, DIR_POS});
         write_csr(CSR_X_SPEED, 16'h0FFF);
         write_csr(CSR_Y_SPEED, 16'h0FFF);
      end else begin
         write_csr(CSR_FRAME_PERIOD, pick_period());
         write_csr(CSR_MOVE_PERIOD, pick_period());
         write_csr(CSR_FRAME_TOTAL, pick_total());
         write_csr(CSR_LOOP_ENABLE, 16'($urandom));
         write_csr(CSR_X_DIRECTION, 16'($urandom));
         write_csr(CSR_Y_DIRECTION, 16'($urandom));
         write_csr(CSR_X_SPEED, pick_speed());
         write_csr(CSR_Y_SPEED, pick_speed());
      end
   endtask

   initial begin
      int regime;
      int set_no;
      int i;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: a single frame and no motion.
      add_tick(16'd0);
      add_tick(16'd1);
      add_tick(16'd58);
      finish_batch(1'b0, 1'b0);

      // Short non-looping run: advance, reach the last frame, keep ticking after death.
      write_csr(CSR_FRAME_TOTAL, 16'd4);
      write_csr(CSR_X_DIRECTION, {14'd0, DIR_POS});
      write_csr(CSR_Y_DIRECTION, {14'h3FFF, DIR_NEG});
      write_csr(CSR_X_SPEED, 16'h0FFF);
      write_csr(CSR_Y_SPEED, 16'd1);
      add_tick(16'd1);
      add_tick(16'd119);
      add_tick(16'd60);
      add_tick(16'd60);
      add_tick(16'hFFFF);
      finish_batch(1'b0, 1'b0);

      // Looping with many frames per tick; doubled negative step.
      write_csr(CSR_LOOP_ENABLE, 16'd1);
      write_csr(CSR_FRAME_TOTAL, {7'd0, FRAME_CAP});
      write_csr(CSR_FRAME_PERIOD, 16'd1);
      write_csr(CSR_MOVE_PERIOD, 16'hFFFF);
      write_csr(CSR_X_DIRECTION, {14'd0, DIR_NEG2});
      write_csr(CSR_Y_DIRECTION, {14'd0, DIR_NONE});
      write_csr(CSR_Y_SPEED, 16'h0FFF);
      add_tick(16'hFFFF);
      add_tick(16'hFFFF);
      add_tick(16'd300);
      add_tick(16'd0);
      finish_batch(1'b0, 1'b0);

      // Frame total of zero acts as one.
      write_csr(CSR_FRAME_TOTAL, 16'd0);
      add_tick(16'd5);
      add_tick(16'hFFFF);
      finish_batch(1'b0, 1'b0);

      // Oversized frame total clamps to the frame limit.
      write_csr(CSR_FRAME_TOTAL, 16'd511);
      write_csr(CSR_FRAME_PERIOD, 16'd3);
      add_tick(16'd1000);
      add_tick(16'd2);
      finish_batch(1'b0, 1'b0);

      // Lower the total under the current frame: index holds, then wraps or clamps.
      write_csr(CSR_FRAME_TOTAL, {7'd0, FRAME_CAP});
      write_csr(CSR_FRAME_PERIOD, 16'd1);
      add_tick(16'd250);
      finish_batch(1'b0, 1'b0);
      write_csr(CSR_FRAME_TOTAL, 16'd3);
      add_tick(16'd0);
      add_tick(16'd7);
      finish_batch(1'b0, 1'b0);
      write_csr(CSR_FRAME_TOTAL, {7'd0, FRAME_CAP});
      add_tick(16'd200);
      finish_batch(1'b0, 1'b0);
      write_csr(CSR_LOOP_ENABLE, 16'd0);
      write_csr(CSR_FRAME_TOTAL, 16'd2);
      add_tick(16'd1);
      finish_batch(1'b0, 1'b0);

      // Zero periods: accumulators only grow, then a period turns it into steps.
      write_csr(CSR_FRAME_TOTAL, 16'd5);
      write_csr(CSR_FRAME_PERIOD, 16'd0);
      write_csr(CSR_MOVE_PERIOD, 16'd0);
      add_tick(16'hFFFF);
      add_tick(16'hFFFF);
      finish_batch(1'b0, 1'b0);
      write_csr(CSR_FRAME_PERIOD, 16'd60);
      write_csr(CSR_MOVE_PERIOD, 16'd30);
      add_tick(16'd0);
      finish_batch(1'b0, 1'b0);

      // Random settings under three idling patterns.
      for (regime = 0; regime < 3; regime++) begin
         @(posedge clock);
         send_idle_pct = (regime == 0) ? 25 : (regime == 1) ? 75 : 0;
         recv_idle_pct = (regime == 0) ? 75 : (regime == 1) ? 25 : 0;
         for (set_no = 0; set_no < 7; set_no++) begin
            pick_settings(set_no < 2 ? set_no + 1 : 0);
            for (i = 0; i < 82; i++)
               add_tick(pick_elapsed());
            finish_batch(regime == 0 && set_no == 2, regime == 1 && set_no == 3);
         end
      end

      // Grow both accumulators large with zero periods, then release them with short periods.
      write_csr(CSR_FRAME_TOTAL, 16'd1);
      write_csr(CSR_FRAME_PERIOD, 16'd0);
      write_csr(CSR_MOVE_PERIOD, 16'd0);
      for (i = 0; i < 16; i++)
         add_tick(16'hFFFF);
      finish_batch(1'b0, 1'b0);
      write_csr(CSR_FRAME_TOTAL, {7'd0, FRAME_CAP});
      write_csr(CSR_LOOP_ENABLE, 16'd1);
      write_csr(CSR_FRAME_PERIOD, 16'd7);
      write_csr(CSR_MOVE_PERIOD, 16'd13);
      write_csr(CSR_X_DIRECTION, {14'd0, DIR_NEG2});
      write_csr(CSR_Y_DIRECTION, {14'd0, DIR_POS});
      write_csr(CSR_X_SPEED, 16'h0FFF);
      write_csr(CSR_Y_SPEED, 16'd1);
      add_tick(16'd0);
      add_tick(16'hFFFF);
      finish_batch(1'b0, 1'b0);

      // Catch any stray response.
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d tick responses over %0d register writes.", ticks_checked,
               csr_writes);
      $display("Run covered single/oversized/zero totals, stale frames, big backlogs, stalls.");
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("Timeout with %0d responses outstanding.", pending_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

[sprite_animation_timer.f]
+incdir+rtl
rtl/sat_pkg.sv
rtl/sat_div.sv
rtl/sprite_animation_timer.sv
tb/sprite_animation_timer_test.sv
